### rtl/keyvalues_text_tokenizer_macros.svh
// Assertion macros for the key/value text tokenizer checker.
// Needs aclk and aresetn in scope where used.
`ifndef KEYVALUES_TEXT_TOKENIZER_MACROS_SVH
`define KEYVALUES_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication
`define KVTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kvtt_pkg.sv
// Shared types, constants and helpers for the key/value text tokenizer.
// No dependencies.
`default_nettype none

package kvtt_pkg;

    localparam int POS_WIDTH   = 24;
    localparam int FIELD_WIDTH = 24;
    localparam int WIDE_WIDTH  = (POS_WIDTH > FIELD_WIDTH) ? POS_WIDTH : FIELD_WIDTH;
    localparam int TOKEN_WIDTH = 3 + 2 * FIELD_WIDTH;
    localparam int TDATA_WIDTH = ((TOKEN_WIDTH + 7) / 8) * 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef logic [POS_WIDTH-1:0]   pos_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;

    typedef enum logic [2:0] {
        KIND_EOS     = 3'd0,
        KIND_OPEN    = 3'd1,
        KIND_CLOSE   = 3'd2,
        KIND_NEWLINE = 3'd3,
        KIND_IDENT   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_UNQ     = 2'd1,
        MODE_QUOTED  = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    // packed so that kind sits in the lowest bits
    typedef struct packed {
        field_t length;
        field_t start;
        kind_t  kind;
    } token_t;

    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } fifo_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic field_t to_field(input pos_t v);
        logic [WIDE_WIDTH-1:0] wide;
        wide = WIDE_WIDTH'(v);
        return wide[FIELD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/keyvalues_text_tokenizer.sv
// A byte's first token word is written to the token queue as the byte is accepted,
// then moved into the output register once that register is free to take it.
// One byte per cycle in while the queue is not full; tokens leave one word per cycle
// while m_tready allows; a byte ending an identifier and giving a second token yields two words.
// A 4-entry token queue between lexer and output stage absorbs output stalls.
// Reset: synchronous, active-low aresetn clears lexer state, queue and output stage.
`default_nettype none

module keyvalues_text_tokenizer (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [7:0] char_in
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [kvtt_pkg::TDATA_WIDTH-1:0] m_tdata,   // [2:0] token_kind,
                                                        // [26:3] token_start,
                                                        // [50:27] token_length
    output logic                             m_tlast    // last_of_run
);
    import kvtt_pkg::*;

    logic        push, pop;
    fifo_entry_t push_entry, head;
    fifo_stat_t  fifo_stat;

    kvtt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    kvtt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .fifo_stat  (fifo_stat)
    );

    kvtt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/kvtt_front.sv
// Lexer front end: takes one byte per cycle while the token queue is not full, updates lexer state, queues tokens.
// Depends on kvtt_pkg.
`default_nettype none

module kvtt_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [7:0]            s_tdata,   // [7:0] char_in
    input  kvtt_pkg::fifo_stat_t  fifo_stat,
    output logic                  push,
    output kvtt_pkg::fifo_entry_t push_entry
);
    import kvtt_pkg::*;

    mode_t mode_reg, mode_next;
    logic  esc_reg, esc_next;
    logic  slash_reg, slash_next;
    pos_t  off_reg, off_next;
    pos_t  istart_reg, istart_next;

    logic       accept;
    logic [7:0] c;
    pos_t       cur_pos, prev_pos;
    logic       id_v, sg_v, eos, run_unq, run_idle, unq_esc;
    pos_t       id_start, id_end;
    kind_t      sg_kind;
    token_t     id_tok, sg_tok;

    assign c        = s_tdata;
    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign cur_pos  = off_reg;
    assign prev_pos = off_reg - pos_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            esc_reg    <= 1'b0;
            slash_reg  <= 1'b0;
            off_reg    <= '0;
            istart_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            slash_reg  <= slash_next;
            off_reg    <= off_next;
            istart_reg <= istart_next;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        slash_next  = slash_reg;
        istart_next = istart_reg;
        off_next    = cur_pos + pos_t'(1);
        id_v        = 1'b0;
        id_start    = istart_reg;
        id_end      = cur_pos;
        sg_v        = 1'b0;
        sg_kind     = KIND_EOS;
        eos         = 1'b0;
        run_unq     = 1'b0;
        run_idle    = 1'b0;
        unq_esc     = 1'b0;

        unique case (mode_reg)
            MODE_COMMENT: begin
                if (c == CH_NUL) begin
                    eos = 1'b1;
                end else if (c == CH_LF || c == CH_CR) begin
                    sg_v      = 1'b1;
                    sg_kind   = KIND_NEWLINE;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                if (c == CH_NUL) begin
                    id_v = 1'b1;
                    eos  = 1'b1;
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == CH_QUOTE) begin
                    id_v      = 1'b1;
                    mode_next = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end
            end
            MODE_UNQ: begin
                slash_next = 1'b0;
                if (slash_reg && c == CH_SLASH) begin
                    id_v      = 1'b1;
                    id_end    = prev_pos;
                    mode_next = MODE_COMMENT;
                end else begin
                    run_unq = 1'b1;
                    unq_esc = esc_reg;
                end
            end
            MODE_IDLE: begin
                if (slash_reg) begin
                    slash_next = 1'b0;
                    if (c == CH_SLASH) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        // lone slash opens an unquoted identifier
                        mode_next   = MODE_UNQ;
                        esc_next    = 1'b0;
                        istart_next = prev_pos;
                        id_start    = prev_pos;
                        run_unq     = 1'b1;
                    end
                end else begin
                    run_idle = 1'b1;
                end
            end
        endcase

        if (run_unq) begin
            if (c == CH_NUL) begin
                id_v = 1'b1;
                eos  = 1'b1;
            end else if (unq_esc) begin
                esc_next = 1'b0;
            end else begin
                case (c) inside
                    CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_OPEN, CH_CLOSE, CH_QUOTE: begin
                        id_v      = 1'b1;
                        mode_next = MODE_IDLE;
                        run_idle  = 1'b1;
                    end
                    CH_SLASH:  slash_next = 1'b1;
                    CH_BSLASH: esc_next   = 1'b1;
                    default: ;
                endcase
            end
        end

        if (run_idle) begin
            case (c) inside
                CH_SPACE, CH_TAB: ;
                CH_SLASH: slash_next = 1'b1;
                CH_NUL:   eos = 1'b1;
                CH_OPEN: begin
                    sg_v    = 1'b1;
                    sg_kind = KIND_OPEN;
                end
                CH_CLOSE: begin
                    sg_v    = 1'b1;
                    sg_kind = KIND_CLOSE;
                end
                CH_LF, CH_CR: begin
                    sg_v    = 1'b1;
                    sg_kind = KIND_NEWLINE;
                end
                CH_QUOTE: begin
                    mode_next   = MODE_QUOTED;
                    istart_next = cur_pos + pos_t'(1);
                end
                default: begin
                    mode_next   = MODE_UNQ;
                    istart_next = cur_pos;
                    esc_next    = (c == CH_BSLASH);
                end
            endcase
        end

        if (eos) begin
            sg_v        = 1'b1;
            sg_kind     = KIND_EOS;
            mode_next   = MODE_IDLE;
            esc_next    = 1'b0;
            slash_next  = 1'b0;
            off_next    = '0;
            istart_next = '0;
        end
    end

    always_comb begin
        id_tok.kind   = KIND_IDENT;
        id_tok.start  = to_field(id_start);
        id_tok.length = to_field(id_end - id_start);
        sg_tok.kind   = sg_kind;
        sg_tok.start  = to_field(cur_pos);
        sg_tok.length = field_t'(1);
    end

    assign push              = accept && (id_v || sg_v);
    assign push_entry.two    = id_v && sg_v;
    assign push_entry.first  = id_v ? id_tok : sg_tok;
    assign push_entry.second = sg_tok;

endmodule

`default_nettype wire

### rtl/kvtt_queue.sv
// Short token queue between lexer front end and output stage.
// Depends on kvtt_pkg.
`default_nettype none

module kvtt_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  kvtt_pkg::fifo_entry_t push_entry,
    input  wire                   pop,
    output kvtt_pkg::fifo_entry_t head,
    output kvtt_pkg::fifo_stat_t  fifo_stat
);
    import kvtt_pkg::*;

    fifo_entry_t        slots[FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

    assign head            = slots[rd_ptr_reg];
    assign fifo_stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign fifo_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

### rtl/kvtt_back.sv
// Output stage: drains queued entries of one or two tokens, one word per cycle while m_tready allows, into a register.
// Depends on kvtt_pkg.
`default_nettype none

module kvtt_back (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  kvtt_pkg::fifo_entry_t                 head,
    input  kvtt_pkg::fifo_stat_t                  fifo_stat,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [kvtt_pkg::TDATA_WIDTH-1:0]      m_tdata,  // token_kind, token_start,
                                                            // token_length, zero pad
    output logic                                  m_tlast   // last_of_run
);
    import kvtt_pkg::*;

    token_t out_tok_reg;
    logic   out_valid_reg;
    logic   out_last_reg;
    logic   phase_reg;
    logic   load;

    assign load = (!out_valid_reg || m_tready) && !fifo_stat.empty;
    assign pop  = load && (phase_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= !phase_reg && head.two;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_tok_reg  <= phase_reg ? head.second : head.first;
            out_last_reg <= phase_reg || !head.two;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_WIDTH-TOKEN_WIDTH){1'b0}}, out_tok_reg};

endmodule

`default_nettype wire

### rtl/kvtt_checker.sv
// Port-level checks for the key/value text tokenizer, bound to the top level.
// Depends on kvtt_pkg and keyvalues_text_tokenizer_macros.svh.
`default_nettype none
`include "keyvalues_text_tokenizer_macros.svh"

module kvtt_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [kvtt_pkg::TDATA_WIDTH-1:0]  m_tdata,
    input wire                              m_tlast
);
    import kvtt_pkg::*;

    logic [2:0]   kind;
    field_t       length;

    assign kind   = m_tdata[2:0];
    assign length = m_tdata[3+2*FIELD_WIDTH-1:3+FIELD_WIDTH];

    `KVTT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled word changed")
    `KVTT_ASSERT_NOW(a_kind, m_tvalid, kind == KIND_EOS || kind == KIND_OPEN || kind == KIND_CLOSE || kind == KIND_NEWLINE || kind == KIND_IDENT, "bad token kind")
    `KVTT_ASSERT_NOW(a_single_len, m_tvalid && kind != KIND_IDENT, length == field_t'(1), "single-byte token length not 1")
    `KVTT_ASSERT_NOW(a_first_ident, m_tvalid && !m_tlast, kind == KIND_IDENT, "non-final word is not an identifier")

endmodule

bind keyvalues_text_tokenizer kvtt_checker u_kvtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### sim/kvtt_token_checker.sv
`timescale 1ns / 1ps
// Checker for the key/value text tokenizer: watches the byte and token channels.
// It predicts every token word from its own lexer model and compares them in order.
// Depends on kvtt_pkg for the kind, mode and character constants.

module kvtt_token_checker
    import kvtt_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    input  wire                       s_tready,
    input  wire  [7:0]                s_tdata,
    input  wire                       m_tvalid,
    input  wire                       m_tready,
    input  wire  [TDATA_WIDTH-1:0]    m_tdata,
    input  wire                       m_tlast,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic   last;
        field_t length;
        field_t start;
        kind_t  kind;
    } token_word_t;

    token_word_t expected_tokens[$];

    mode_t       lex_mode_q;
    logic        escape_q;
    logic        slash_q;
    pos_t        offset_q;
    pos_t        ident_start_q;

    token_word_t byte_tokens[2];
    int          byte_token_count;
    int          words_seen;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch at token word %0d: %s got %0h want %0h",
                 words_seen, what, got, want);
        fail_count++;
    endtask

    task automatic push_token(input kind_t kind, input pos_t start, input pos_t len);
        if (byte_token_count < 2) begin
            byte_tokens[byte_token_count].kind   = kind;
            byte_tokens[byte_token_count].start  = field_t'(start);
            byte_tokens[byte_token_count].length = field_t'(len);
            byte_tokens[byte_token_count].last   = 1'b0;
            byte_token_count++;
        end
    endtask

    task automatic push_ident(input pos_t stop_at);
        push_token(KIND_IDENT, ident_start_q, stop_at - ident_start_q);
    endtask

    task automatic end_stream(input pos_t p);
        push_token(KIND_EOS, p, pos_t'(1));
        lex_mode_q    = MODE_IDLE;
        escape_q      = 1'b0;
        slash_q       = 1'b0;
        offset_q      = '0;
        ident_start_q = '0;
    endtask

    task automatic lex_idle_byte(input logic [7:0] c, input pos_t p);
        case (c)
            CH_SPACE, CH_TAB: ;
            CH_SLASH: slash_q = 1'b1;
            CH_NUL: end_stream(p);
            CH_OPEN: push_token(KIND_OPEN, p, pos_t'(1));
            CH_CLOSE: push_token(KIND_CLOSE, p, pos_t'(1));
            CH_LF, CH_CR: push_token(KIND_NEWLINE, p, pos_t'(1));
            CH_QUOTE: begin
                lex_mode_q    = MODE_QUOTED;
                ident_start_q = p + 1'b1;
            end
            default: begin
                lex_mode_q    = MODE_UNQ;
                ident_start_q = p;
                if (c == CH_BSLASH)
                    escape_q = 1'b1;
            end
        endcase
    endtask

    task automatic lex_unquoted_byte(input logic [7:0] c, input pos_t p);
        if (c == CH_NUL) begin
            push_ident(p);
            end_stream(p);
        end else if (escape_q) begin
            escape_q = 1'b0;
        end else begin
            case (c)
                CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_OPEN, CH_CLOSE, CH_QUOTE: begin
                    // terminator is then lexed as if idle
                    push_ident(p);
                    lex_mode_q = MODE_IDLE;
                    lex_idle_byte(c, p);
                end
                CH_SLASH: slash_q = 1'b1;
                CH_BSLASH: escape_q = 1'b1;
                default: ;
            endcase
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        pos_t p;
        pos_t prev;
        logic handled;
        p                = offset_q;
        prev             = p - 1'b1;
        offset_q         = p + 1'b1;
        byte_token_count = 0;
        handled          = 1'b0;
        case (lex_mode_q)
            MODE_COMMENT: begin
                if (c == CH_NUL) begin
                    end_stream(p);
                end else if (c == CH_LF || c == CH_CR) begin
                    push_token(KIND_NEWLINE, p, pos_t'(1));
                    lex_mode_q = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                if (c == CH_NUL) begin
                    push_ident(p);
                    end_stream(p);
                end else if (escape_q) begin
                    escape_q = 1'b0;
                end else if (c == CH_QUOTE) begin
                    push_ident(p);
                    lex_mode_q = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    escape_q = 1'b1;
                end
            end
            MODE_UNQ: begin
                if (slash_q) begin
                    slash_q = 1'b0;
                    if (c == CH_SLASH) begin
                        // identifier ends before the first slash
                        push_ident(prev);
                        lex_mode_q = MODE_COMMENT;
                        handled    = 1'b1;
                    end
                end
                if (!handled)
                    lex_unquoted_byte(c, p);
            end
            default: begin
                if (slash_q) begin
                    slash_q = 1'b0;
                    if (c == CH_SLASH) begin
                        lex_mode_q = MODE_COMMENT;
                    end else begin
                        // lone slash opens an identifier
                        lex_mode_q    = MODE_UNQ;
                        escape_q      = 1'b0;
                        ident_start_q = prev;
                        lex_unquoted_byte(c, p);
                    end
                end else begin
                    lex_idle_byte(c, p);
                end
            end
        endcase
        if (byte_token_count > 0)
            byte_tokens[byte_token_count - 1].last = 1'b1;
        for (int i = 0; i < byte_token_count; i++)
            expected_tokens.push_back(byte_tokens[i]);
    endtask

    always @(posedge aclk) begin : monitor
        token_t      got;
        token_word_t want;
        if (!aresetn) begin
            lex_mode_q    = MODE_IDLE;
            escape_q      = 1'b0;
            slash_q       = 1'b0;
            offset_q      = '0;
            ident_start_q = '0;
            expected_tokens.delete();
            fail_count    = 0;
            words_seen    = 0;
            pending       = 0;
        end else begin
            if (s_tvalid && s_tready)
                lex_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata[TOKEN_WIDTH-1:0];
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected word, kind", 24'(got.kind), '0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 24'(got.kind), 24'(want.kind));
                    if (got.start !== want.start)
                        report_mismatch("start", got.start, want.start);
                    if (got.length !== want.length)
                        report_mismatch("length", got.length, want.length);
                    if (m_tlast !== want.last)
                        report_mismatch("last", 24'(m_tlast), 24'(want.last));
                end
                words_seen++;
            end
            pending = expected_tokens.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Top of the key/value text tokenizer regression: clock, reset and byte stimulus.
// Instantiates the tokenizer and kvtt_token_checker; gives the verdict.

module testbench;
    import kvtt_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 340;

    localparam logic [7:0] DIRECTED_TEXT [26] = '{
        CH_OPEN, CH_CLOSE, CH_LF, CH_CR, CH_TAB, CH_SPACE,
        CH_QUOTE, CH_QUOTE,                 // empty quoted
        "a", CH_OPEN,                       // identifier and brace from one byte
        CH_SLASH, "x",                      // lone slash
        CH_SLASH, CH_SLASH, "z", CH_CR,     // comment cuts identifier
        CH_BSLASH, CH_CLOSE,                // escaped brace
        CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_QUOTE,
        8'hFF, CH_BSLASH, CH_NUL,           // backslash before terminator
        CH_NUL
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_WIDTH-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int stall_cycles;

    keyvalues_text_tokenizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    kvtt_token_checker token_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // holds tvalid across back-to-back words; lowered only on an idle cycle
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b inside {CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_QUOTE, CH_SLASH,
                         CH_BSLASH, CH_OPEN, CH_CLOSE});
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b inside {CH_QUOTE, CH_BSLASH});
        return b;
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b inside {CH_LF, CH_CR});
        return b;
    endfunction

    task automatic send_random_piece();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 22) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(9))
                    0: begin
                        send_byte(CH_BSLASH);
                        send_byte(8'($urandom_range(255)));
                    end
                    1: begin
                        send_byte(CH_SLASH);
                        send_byte(word_byte());
                    end
                    default: send_byte(word_byte());
                endcase
            end
        end else if (pick < 36) begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(7) == 0) begin
                    send_byte(CH_BSLASH);
                    send_byte(8'($urandom_range(255)));
                end else begin
                    send_byte(quoted_byte());
                end
            end
            // now and then the stream ends inside the quotes
            send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_QUOTE);
        end else if (pick < 46) begin
            repeat ($urandom_range(1, 3))
                send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        end else if (pick < 54) begin
            send_byte($urandom_range(1) ? CH_LF : CH_CR);
        end else if (pick < 62) begin
            send_byte(CH_OPEN);
        end else if (pick < 70) begin
            send_byte(CH_CLOSE);
        end else if (pick < 78) begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            repeat ($urandom_range(0, 5))
                send_byte(comment_byte());
            send_byte($urandom_range(1) ? CH_LF : CH_CR);
        end else if (pick < 82) begin
            send_byte(CH_NUL);
        end else begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int target;
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target)
            send_random_piece();
        drain_tokens();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent    = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED_TEXT[i])
            send_byte(DIRECTED_TEXT[i]);
        drain_tokens();

        run_phase(7, 57);
        run_phase(57, 7);
        run_phase(0, 0);

        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
